// ===== rtl/xlb_pkg.sv =====
// ----------------------------------------------------------------------------
// xlb_pkg
// shared types, constants and helpers of the xor linear basis block
// ----------------------------------------------------------------------------
package xlb_pkg;

	localparam int WORD_BITS = 61;
	localparam int SLOT_W    = $clog2(WORD_BITS);
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int RANK_W    = 6;
	localparam int OP_W      = 2;

	localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WORD_BITS - 1);
	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		word_t           value;
	} xlb_in_t;

	typedef struct packed {
		word_t             max_xor;
		logic              added;
		logic [RANK_W-1:0] rank;
	} xlb_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} xlb_state_t;

	// requests from the sequencer to the slot store
	typedef struct packed {
		logic              clear;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
	} xlb_store_ctrl_t;

	function automatic logic [RANK_W-1:0] rank_of(input logic [CNT_W-1:0] cnt);
		logic [RANK_W-1:0] r;
		if ({1'b0, cnt} > (CNT_W + 1)'(RANK_MAX)) begin
			r = RANK_MAX;
		end else begin
			r = RANK_W'(cnt);
		end
		return r;
	endfunction

endpackage

// ===== rtl/xor_linear_basis.sv =====
// ----------------------------------------------------------------------------
// xor_linear_basis
// gf(2) linear basis of 61-bit words, one memory slot per leading bit
// ----------------------------------------------------------------------------
// results: clear and unused codes give their result in the cycle after the transaction
// insert and query walk the slot memory top-down, one slot per cycle: the result
// comes as the walk ends, and an independent insert stops early at the slot it fills
// flow: a full walk fetches the top slot and then visits each slot in turn, and is busy
// all along; clear and unused codes one per cycle; next one starts on result edge
// reset: arst_n empties every slot and zeroes the rank; the receiver cannot stall
module xor_linear_basis
	import xlb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  xlb_in_t  cmd,
	output logic     done,
	output xlb_out_t result
);

	// sequencer state
	xlb_state_t        state_q, state_d;
	logic              is_query_q, is_query_d;
	logic [SLOT_W-1:0] slot_s1, slot_d;     // slot whose data arrives this cycle
	word_t             vec_q, vec_d;         // remainder for insert, running max for query
	logic [CNT_W-1:0]  count_q, count_d;
	logic              done_q, done_d;
	xlb_out_t          result_q, result_d;

	xlb_store_ctrl_t   ctrl;
	word_t             rd_data;
	logic              rd_occ;
	logic              accept;
	logic              cur_bit;
	logic              last_slot;

	xlb_slot_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.wr_data (vec_q),
		.rd_data (rd_data),
		.rd_occ  (rd_occ)
	);

	assign accept    = start && (state_q == ST_IDLE);
	assign cur_bit   = vec_q[slot_s1];
	assign last_slot = (slot_s1 == '0);

	always_comb begin
		state_d    = state_q;
		is_query_d = is_query_q;
		slot_d     = slot_s1;
		vec_d      = vec_q;
		count_d    = count_q;
		done_d     = 1'b0;
		result_d   = result_q;
		ctrl       = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (cmd.operation == OP_INSERT || cmd.operation == OP_QUERY) begin
						// start the walk: fetch the top slot now
						ctrl.rd_en  = 1'b1;
						ctrl.rd_addr = SLOT_TOP;
						slot_d      = SLOT_TOP;
						is_query_d  = (cmd.operation == OP_QUERY);
						vec_d       = (cmd.operation == OP_QUERY) ? '0 : cmd.value;
						state_d     = ST_WALK;
					end else begin
						// clear, or unused code that leaves the basis alone
						if (cmd.operation == OP_CLEAR) begin
							ctrl.clear = 1'b1;
							count_d    = '0;
						end
						done_d           = 1'b1;
						result_d.max_xor = '0;
						result_d.added   = 1'b0;
						result_d.rank    = rank_of((cmd.operation == OP_CLEAR) ? '0 : count_q);
					end
				end
			end
			ST_WALK: begin
				// prefetch the next lower slot while this one is handled
				ctrl.rd_en   = !last_slot;
				ctrl.rd_addr = slot_s1 - SLOT_W'(1);
				slot_d       = slot_s1 - SLOT_W'(1);
				if (is_query_q) begin
					// xor in a slot only when its leading bit is still clear
					if (rd_occ && !cur_bit) begin
						vec_d = vec_q ^ rd_data;
					end
					if (last_slot) begin
						state_d          = ST_IDLE;
						done_d           = 1'b1;
						result_d.max_xor = vec_d;
						result_d.added   = 1'b0;
						result_d.rank    = rank_of(count_q);
					end
				end else if (cur_bit && !rd_occ) begin
					// empty slot under the leading bit: the remainder goes here
					ctrl.wr_en       = 1'b1;
					ctrl.wr_addr     = slot_s1;
					count_d          = count_q + CNT_W'(1);
					state_d          = ST_IDLE;
					done_d           = 1'b1;
					result_d.max_xor = '0;
					result_d.added   = 1'b1;
					result_d.rank    = rank_of(count_d);
				end else begin
					if (cur_bit) begin
						vec_d = vec_q ^ rd_data;
					end
					if (last_slot) begin
						// reduced to zero: dependent value
						state_d          = ST_IDLE;
						done_d           = 1'b1;
						result_d.max_xor = '0;
						result_d.added   = 1'b0;
						result_d.rank    = rank_of(count_q);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			is_query_q <= 1'b0;
			slot_s1    <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			is_query_q <= is_query_d;
			slot_s1    <= slot_d;
			count_q    <= count_d;
			done_q     <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		vec_q    <= vec_d;
		result_q <= result_d;
	end

	assign busy   = (state_q == ST_WALK);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/xlb_slot_store.sv =====
// ----------------------------------------------------------------------------
// xlb_slot_store
// basis slot memory with registered reads and per-slot occupied bits
// ----------------------------------------------------------------------------
module xlb_slot_store
	import xlb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  xlb_store_ctrl_t ctrl,
	input  word_t           wr_data,
	output word_t           rd_data,
	output logic            rd_occ
);

	word_t                  mem [WORD_BITS];
	logic [WORD_BITS-1:0]   occ_q;
	word_t                  rd_data_s1;
	logic                   rd_occ_s1;

	// payload array, no reset
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_s1 <= mem[ctrl.rd_addr];
		end
	end

	// occupied flags, cleared all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			rd_occ_s1 <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				occ_q <= '0;
			end else if (ctrl.wr_en) begin
				occ_q[ctrl.wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rd_occ_s1 <= occ_q[ctrl.rd_addr];
			end
		end
	end

	assign rd_data = rd_data_s1;
	assign rd_occ  = rd_occ_s1;

endmodule

// ===== rtl/xlb_checker.sv =====
// ----------------------------------------------------------------------------
// xlb_port_props
// port-level checks of the xor linear basis, bound to the top level
// ----------------------------------------------------------------------------
module xlb_port_props
	import xlb_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input xlb_in_t  cmd,
	input logic     done,
	input xlb_out_t result
);

	// a result only ever shows once the walk is over
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// clear answers in the next cycle with an empty basis
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.operation == OP_CLEAR |=>
			done && result.rank == '0 && !result.added && result.max_xor == '0)
		else $error("clear result wrong");

	// insert and query walk the slots and cannot answer at once
	a_walk_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.operation == OP_INSERT || cmd.operation == OP_QUERY) |=>
			busy && !done)
		else $error("walk did not start");

	// a stored word leaves at least one occupied slot and no max value
	a_added_rank: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.added |-> result.rank != '0 && result.max_xor == '0)
		else $error("added result inconsistent");

endmodule

bind xor_linear_basis xlb_port_props u_xlb_port_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

// ===== tb/xlb_checker.sv =====
// ----------------------------------------------------------------------------
// xlb_checker
// watches the command and result channels of the xor linear basis block,
// keeps its own gf(2) basis and compares every result with the prediction
// ----------------------------------------------------------------------------
module xlb_checker
	import xlb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  xlb_in_t     cmd,
	input  logic        done,
	input  xlb_out_t    result,
	output int unsigned fail_count,
	output int unsigned owed
);

	word_t       slots [WORD_BITS];
	int unsigned filled;
	xlb_out_t    basis_outcomes_q [$];
	int unsigned mismatches;

	// one transaction against the basis kept here
	function automatic xlb_out_t apply_basis_op(input xlb_in_t c);
		xlb_out_t o;
		word_t    v;
		word_t    acc;
		logic     stored;
		o = '0;
		v = c.value;
		acc = '0;
		stored = 1'b0;
		case (c.operation)
			OP_CLEAR: begin
				for (int i = 0; i < WORD_BITS; i++) slots[i] = '0;
				filled = 0;
			end
			OP_INSERT: begin
				for (int i = WORD_BITS - 1; i >= 0 && !stored; i--) begin
					if (v[i]) begin
						if (slots[i] != '0) begin
							v ^= slots[i];
						end else begin
							slots[i] = v;
							filled++;
							stored = 1'b1;
						end
					end
				end
				o.added = stored;
			end
			OP_QUERY: begin
				for (int i = WORD_BITS - 1; i >= 0; i--) begin
					if ((acc ^ slots[i]) > acc) acc ^= slots[i];
				end
				o.max_xor = acc;
			end
			default: begin
			end
		endcase
		o.rank = (filled > RANK_MAX) ? RANK_MAX : RANK_W'(filled);
		return o;
	endfunction

	initial begin
		fail_count = 0;
		owed = 0;
		mismatches = 0;
		filled = 0;
		for (int i = 0; i < WORD_BITS; i++) slots[i] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		xlb_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < WORD_BITS; i++) slots[i] = '0;
			filled = 0;
			basis_outcomes_q.delete();
		end else begin
			// results first: a new transaction may start on the edge its predecessor ends
			if (done) begin
				if (basis_outcomes_q.size() == 0) begin
					fail_count++;
					if (mismatches < 10)
						$display("result with no transaction pending: %h", result);
					mismatches++;
				end else begin
					want = basis_outcomes_q.pop_front();
					if (result.max_xor !== want.max_xor || result.added !== want.added ||
						result.rank !== want.rank) begin
						fail_count++;
						if (mismatches < 10)
							$display("mismatch: max_xor %h/%h added %b/%b rank %0d/%0d (exp/act)",
								want.max_xor, result.max_xor, want.added, result.added,
								want.rank, result.rank);
						mismatches++;
					end
				end
			end
			if (start && !busy) basis_outcomes_q = {basis_outcomes_q, apply_basis_op(cmd)};
		end
		owed <= basis_outcomes_q.size();
	end

endmodule

// ===== tb/xor_linear_basis_tb.sv =====
// ----------------------------------------------------------------------------
// xor_linear_basis_tb
// drives clear, insert, query and unused-code transactions into the basis
// block, directed corner cases first and then random episodes, and gives the
// verdict from the failure count of the checker
// ----------------------------------------------------------------------------
module xor_linear_basis_tb;
	import xlb_pkg::*;

	localparam int N_ITEMS      = 1250;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 80;

	// the fourth operation code has no meaning, the block must only report rank
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	xlb_in_t     cmd;
	xlb_out_t    result;
	int unsigned fail_count;
	int unsigned owed;
	int unsigned cycles = 0;
	int unsigned sent = 0;
	// words inserted since the last clear, used to build dependent values
	word_t       basis_words [$];

	xor_linear_basis u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	xlb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.owed       (owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// hard stop in case the block hangs
	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic word_t rand_word();
		return word_t'({$urandom(), $urandom()});
	endfunction

	// insert values: random words, plus shifted words for low leading bits,
	// combinations of stored words (dependent), zero, single bits and all ones
	function automatic word_t pick_value();
		word_t w;
		int    k;
		w = '0;
		k = $urandom_range(15);
		if (k < 6) begin
			w = rand_word();
		end else if (k < 9) begin
			w = rand_word() >> $urandom_range(WORD_BITS - 1);
		end else if (k < 12) begin
			foreach (basis_words[i]) if ($urandom_range(1)) w ^= basis_words[i];
			// sometimes nudge a dependent word off the span
			if (k == 11) w ^= word_t'(1) << $urandom_range(WORD_BITS - 1);
		end else if (k == 12) begin
			w = '0;
		end else if (k < 15) begin
			w = word_t'(1) << $urandom_range(WORD_BITS - 1);
		end else begin
			w = '1;
		end
		return w;
	endfunction

	// sender gap probability per phase: light, heavy, then none
	function automatic int unsigned gap_pct();
		if (sent < N_ITEMS / 3) return 10;
		else if (sent < 2 * N_ITEMS / 3) return 66;
		return 0;
	endfunction

	// one transaction: random gaps with noise on cmd, then hold start until taken
	task automatic issue(input logic [OP_W-1:0] op, input word_t v);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct()) begin
			start <= 1'b0;
			cmd   <= '{operation: OP_W'($urandom()), value: rand_word()};
			@(negedge clk);
		end
		start <= 1'b1;
		cmd   <= '{operation: op, value: v};
		do @(posedge clk); while (busy);
		sent++;
		if (op == OP_CLEAR) basis_words.delete();
		else if (op == OP_INSERT) basis_words = {basis_words, v};
	endtask

	// a clear followed by a run of inserts and queries; some runs are long
	// enough to fill every slot and then hit mostly dependent words
	task automatic run_episode();
		int unsigned len;
		int unsigned r;
		issue(OP_CLEAR, rand_word());
		len = ($urandom_range(3) == 0) ? $urandom_range(62, 90) : $urandom_range(1, 40);
		for (int j = 0; j < len; j++) begin
			r = $urandom_range(99);
			if (r < 70) issue(OP_INSERT, pick_value());
			else if (r < 94) issue(OP_QUERY, rand_word());
			else if (r < 97) issue(OP_UNUSED, rand_word());
			else issue(OP_CLEAR, rand_word());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed corners
		issue(OP_QUERY, '1);                        // query of an empty basis
		issue(OP_INSERT, '0);                       // zero never stores
		issue(OP_UNUSED, '1);                       // unused code on empty basis
		issue(OP_INSERT, '1);                       // top slot from all ones
		issue(OP_INSERT, '1);                       // same word again is dependent
		issue(OP_INSERT, word_t'(1));               // lowest slot
		issue(OP_INSERT, word_t'(1) << (WORD_BITS - 1));
		issue(OP_INSERT, word_t'({(WORD_BITS + 1) / 2 {2'b01}}));
		issue(OP_INSERT, word_t'({(WORD_BITS + 1) / 2 {2'b10}}));
		issue(OP_QUERY, '0);
		issue(OP_UNUSED, '0);                       // unused code keeps the rank
		issue(OP_CLEAR, '1);
		issue(OP_QUERY, '0);                        // cleared basis gives zero
		issue(OP_INSERT, word_t'(3));
		issue(OP_INSERT, word_t'(2));
		issue(OP_INSERT, word_t'(1));               // 1 = 3 ^ 2, dependent
		issue(OP_INSERT, word_t'(4));
		issue(OP_QUERY, '1);
		issue(OP_INSERT, word_t'(7));               // reduces to zero
		issue(OP_CLEAR, '0);

		// random episodes across the three gap phases
		while (sent < N_ITEMS) run_episode();

		@(negedge clk);
		start <= 1'b0;

		// drain: wait for every owed result, then some settling time
		while (owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && owed == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/xlb_pkg.sv
rtl/xlb_slot_store.sv
rtl/xor_linear_basis.sv
rtl/xlb_checker.sv
tb/xlb_checker.sv
tb/xor_linear_basis_tb.sv
